@@ hw/rtl/rational_arithmetic_unit_macros.svh @@
// Assertion macros used by the file that checks this block.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rau_pkg.sv @@
`timescale 1ns / 1ps

package rau_pkg;

   // Operation codes carried by an input item.
   localparam logic [3:0] KIND_NORM  = 4'd0;
   localparam logic [3:0] KIND_ADD   = 4'd1;
   localparam logic [3:0] KIND_SUB   = 4'd2;
   localparam logic [3:0] KIND_MUL   = 4'd3;
   localparam logic [3:0] KIND_DIV   = 4'd4;
   localparam logic [3:0] KIND_NEG   = 4'd5;
   localparam logic [3:0] KIND_ABS   = 4'd6;
   localparam logic [3:0] KIND_CMP   = 4'd7;
   localparam logic [3:0] KIND_FLOOR = 4'd8;
   localparam logic [3:0] KIND_CEIL  = 4'd9;
   localparam logic [3:0] KIND_TRUNC = 4'd10;

   // Error codes of a result item.
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_ZERO = 2'd1;
   localparam logic [1:0] ERR_OVF  = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD,
      ST_SHL,
      ST_DIVN,
      ST_DIVD,
      ST_REDDONE,
      ST_OP,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ADD,
      ST_SUB2,
      ST_CMP,
      ST_INTDIV,
      ST_EMIT,
      ST_OUT
   } state_type;

   // Which fraction the running reduction belongs to.
   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_R
   } phase_type;

endpackage

@@ hw/rtl/rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// A zero denominator or an unknown operation goes from the idle state straight to the output
// state. Any other item needs one to three reductions, each a binary gcd, the common power
// of two shifted back and two restoring divisions by the gcd.
// Throughput: one item at a time; ready again once the result enters the output register.
// Reset (synchronous, active high) clears the sequencer and the output valid.
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_kind,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic signed [31:0] rsp_int_result,
   output logic               rsp_is_less,
   output logic               rsp_is_equal,
   output logic [1:0]         rsp_error
);

   localparam int W  = WIDTH;
   localparam int DW = 2 * WIDTH;
   localparam int L  = 2 * WIDTH + 1;
   localparam int AW = L + 1;
   localparam int KW = $clog2(L + 1);
   localparam int CW = $clog2(L);
   localparam logic [L-1:0] LIM = L'(1) << (W - 1);

   rau_pkg::state_type state_ff, state_in;
   rau_pkg::phase_type phase_ff, phase_in;

   logic [3:0]    kind_ff, kind_in;
   logic [W-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [L-1:0]  u_ff, u_in, v_ff, v_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [L-1:0]  rn_ff, rn_in, rd_ff, rd_in;
   logic          rneg_ff, rneg_in;
   logic [L-1:0]  dq_ff, dq_in, drem_ff, drem_in;
   logic [DW-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [31:0]   o_num_ff, o_num_in, o_int_ff, o_int_in;
   logic [30:0]   o_den_ff, o_den_in;
   logic          o_less_ff, o_less_in, o_eq_ff, o_eq_in;
   logic [1:0]    o_err_ff, o_err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_num_ff, rsp_num_in, rsp_int_ff, rsp_int_in;
   logic [30:0]   rsp_den_ff, rsp_den_in;
   logic          rsp_less_ff, rsp_less_in, rsp_eq_ff, rsp_eq_in;
   logic [1:0]    rsp_err_ff, rsp_err_in;

   // Shared add/subtract unit and the multiplier.
   logic [AW-1:0] alu_x, alu_y;
   logic          alu_sub;
   logic [AW:0]   alu_sum;
   logic          alu_borrow;
   logic [W-1:0]  mul_a, mul_b;
   logic [DW-1:0] mul_p;

   // Operand split of an arriving item.
   logic [W-1:0] va_n, va_d, vb_n, vb_d;
   logic [W-1:0] ma_n, ma_d, mb_n, mb_d;
   logic         binary;

   // Reduction start request, shared by every place that reduces a fraction.
   logic          red_go;
   logic [L-1:0]  red_n, red_d;
   logic          red_neg;
   rau_pkg::phase_type red_phase;

   // Divider step values and other scratch.
   logic [L-1:0]  dq_step, drem_step;
   logic          sy, bad, frac;
   logic [31:0]   m32, n32;

   assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + (AW + 1)'(alu_sub);
   assign alu_borrow = alu_sub & ~alu_sum[AW];
   assign mul_p = DW'(mul_a) * DW'(mul_b);

   assign va_n = req_a_num[W-1:0];
   assign va_d = req_a_den[W-1:0];
   assign vb_n = req_b_num[W-1:0];
   assign vb_d = req_b_den[W-1:0];
   assign ma_n = va_n[W-1] ? (~va_n + W'(1)) : va_n;
   assign ma_d = va_d[W-1] ? (~va_d + W'(1)) : va_d;
   assign mb_n = vb_n[W-1] ? (~vb_n + W'(1)) : vb_n;
   assign mb_d = vb_d[W-1] ? (~vb_d + W'(1)) : vb_d;

   assign req_ready = (state_ff == rau_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_int_result = rsp_int_ff;
   assign rsp_is_less = rsp_less_ff;
   assign rsp_is_equal = rsp_eq_ff;
   assign rsp_error = rsp_err_ff;

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in = kind_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      aneg_in = aneg_ff;
      bneg_in = bneg_ff;
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      dcnt_in = dcnt_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      rneg_in = rneg_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      o_num_in = o_num_ff;
      o_den_in = o_den_ff;
      o_int_in = o_int_ff;
      o_less_in = o_less_ff;
      o_eq_in = o_eq_ff;
      o_err_in = o_err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      rsp_int_in = rsp_int_ff;
      rsp_less_in = rsp_less_ff;
      rsp_eq_in = rsp_eq_ff;
      rsp_err_in = rsp_err_ff;

      alu_x = {1'b0, u_ff};
      alu_y = {1'b0, v_ff};
      alu_sub = 1'b1;
      mul_a = an_ff;
      mul_b = bd_ff;

      red_go = 1'b0;
      red_n = rn_ff;
      red_d = rd_ff;
      red_neg = rneg_ff;
      red_phase = rau_pkg::PH_R;

      dq_step = dq_ff;
      drem_step = drem_ff;
      sy = 1'b0;
      bad = 1'b0;
      frac = 1'b0;
      m32 = '0;
      n32 = '0;

      binary = (kind_ff == rau_pkg::KIND_ADD) || (kind_ff == rau_pkg::KIND_SUB) ||
               (kind_ff == rau_pkg::KIND_MUL) || (kind_ff == rau_pkg::KIND_DIV) ||
               (kind_ff == rau_pkg::KIND_CMP);

      case (state_ff)
         // Take an item, split the operands and screen out trivial cases.
         rau_pkg::ST_IDLE: begin
            binary = (req_kind == rau_pkg::KIND_ADD) || (req_kind == rau_pkg::KIND_SUB) ||
                     (req_kind == rau_pkg::KIND_MUL) || (req_kind == rau_pkg::KIND_DIV) ||
                     (req_kind == rau_pkg::KIND_CMP);
            if (req_valid) begin
               kind_in = req_kind;
               an_in = ma_n;
               ad_in = ma_d;
               bn_in = mb_n;
               bd_in = mb_d;
               bneg_in = vb_n[W-1] ^ vb_d[W-1];
               o_num_in = '0;
               o_den_in = '0;
               o_int_in = '0;
               o_less_in = 1'b0;
               o_eq_in = 1'b0;
               o_err_in = rau_pkg::ERR_NONE;
               if (req_kind > rau_pkg::KIND_TRUNC) begin
                  state_in = rau_pkg::ST_OUT;
               end else if ((ma_d == '0) || (binary && (mb_d == '0))) begin
                  o_err_in = rau_pkg::ERR_ZERO;
                  state_in = rau_pkg::ST_OUT;
               end else begin
                  red_go = 1'b1;
                  red_n = L'(ma_n);
                  red_d = L'(ma_d);
                  red_neg = va_n[W-1] ^ va_d[W-1];
                  red_phase = rau_pkg::PH_A;
               end
            end
         end

         // Binary gcd: one shift, swap or subtract per cycle.
         rau_pkg::ST_GCD: begin
            if (u_ff == '0) begin
               state_in = rau_pkg::ST_SHL;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (alu_borrow) begin
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               u_in = alu_sum[L-1:0];
            end
         end

         // Restore the common power of two, then divide the numerator.
         rau_pkg::ST_SHL: begin
            if (k_ff == '0) begin
               dq_in = rn_ff;
               drem_in = '0;
               dcnt_in = '0;
               state_in = rau_pkg::ST_DIVN;
            end else begin
               v_in = v_ff << 1;
               k_in = k_ff - KW'(1);
            end
         end

         // Restoring division by v, one quotient bit per cycle.
         rau_pkg::ST_DIVN, rau_pkg::ST_DIVD, rau_pkg::ST_INTDIV: begin
            alu_x = {drem_ff, dq_ff[L-1]};
            alu_y = {1'b0, v_ff};
            drem_step = alu_borrow ? alu_x[L-1:0] : alu_sum[L-1:0];
            dq_step = {dq_ff[L-2:0], ~alu_borrow};
            drem_in = drem_step;
            dq_in = dq_step;
            dcnt_in = dcnt_ff + CW'(1);
            if (dcnt_ff == CW'(L - 1)) begin
               dcnt_in = '0;
               if (state_ff == rau_pkg::ST_DIVN) begin
                  rn_in = dq_step;
                  dq_in = rd_ff;
                  drem_in = '0;
                  state_in = rau_pkg::ST_DIVD;
               end else if (state_ff == rau_pkg::ST_DIVD) begin
                  rd_in = dq_step;
                  state_in = rau_pkg::ST_REDDONE;
               end else begin
                  frac = (drem_step != '0);
                  m32 = 32'(dq_step);
                  if ((kind_ff == rau_pkg::KIND_FLOOR) && aneg_ff && frac) begin
                     m32 = m32 + 32'd1;
                  end else if ((kind_ff == rau_pkg::KIND_CEIL) && !aneg_ff && frac) begin
                     m32 = m32 + 32'd1;
                  end
                  o_int_in = aneg_ff ? (32'd0 - m32) : m32;
                  state_in = rau_pkg::ST_OUT;
               end
            end
         end

         // A reduction has finished: file it where it belongs.
         rau_pkg::ST_REDDONE: begin
            case (phase_ff)
               rau_pkg::PH_A: begin
                  an_in = rn_ff[W-1:0];
                  ad_in = rd_ff[W-1:0];
                  aneg_in = rneg_ff && (rn_ff != '0);
                  if (binary) begin
                     red_go = 1'b1;
                     red_n = L'(bn_ff);
                     red_d = L'(bd_ff);
                     red_neg = bneg_ff;
                     red_phase = rau_pkg::PH_B;
                  end else begin
                     state_in = rau_pkg::ST_OP;
                  end
               end
               rau_pkg::PH_B: begin
                  bn_in = rn_ff[W-1:0];
                  bd_in = rd_ff[W-1:0];
                  bneg_in = rneg_ff && (rn_ff != '0);
                  state_in = rau_pkg::ST_OP;
               end
               default: begin
                  rneg_in = rneg_ff && (rn_ff != '0);
                  state_in = rau_pkg::ST_EMIT;
               end
            endcase
         end

         // Dispatch on the operation once the operands are in lowest terms.
         rau_pkg::ST_OP: begin
            case (kind_ff)
               rau_pkg::KIND_NORM, rau_pkg::KIND_NEG, rau_pkg::KIND_ABS: begin
                  rn_in = L'(an_ff);
                  rd_in = L'(ad_ff);
                  if (kind_ff == rau_pkg::KIND_NEG) begin
                     rneg_in = (an_ff != '0) && !aneg_ff;
                  end else if (kind_ff == rau_pkg::KIND_ABS) begin
                     rneg_in = 1'b0;
                  end else begin
                     rneg_in = aneg_ff;
                  end
                  state_in = rau_pkg::ST_EMIT;
               end
               rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL,
               rau_pkg::KIND_DIV, rau_pkg::KIND_CMP: begin
                  if ((kind_ff == rau_pkg::KIND_DIV) && (bn_ff == '0)) begin
                     o_err_in = rau_pkg::ERR_ZERO;
                     state_in = rau_pkg::ST_OUT;
                  end else begin
                     state_in = rau_pkg::ST_MUL0;
                  end
               end
               rau_pkg::KIND_FLOOR, rau_pkg::KIND_CEIL, rau_pkg::KIND_TRUNC: begin
                  dq_in = L'(an_ff);
                  drem_in = '0;
                  v_in = L'(ad_ff);
                  dcnt_in = '0;
                  state_in = rau_pkg::ST_INTDIV;
               end
               default: begin
                  state_in = rau_pkg::ST_OUT;
               end
            endcase
         end

         // Cross products, one multiplication per cycle.
         rau_pkg::ST_MUL0: begin
            mul_a = an_ff;
            mul_b = (kind_ff == rau_pkg::KIND_MUL) ? bn_ff : bd_ff;
            px_in = mul_p;
            state_in = rau_pkg::ST_MUL1;
         end
         rau_pkg::ST_MUL1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
            py_in = mul_p;
            state_in = rau_pkg::ST_MUL2;
         end
         rau_pkg::ST_MUL2: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
            pz_in = mul_p;
            if (kind_ff == rau_pkg::KIND_MUL) begin
               red_go = 1'b1;
               red_n = L'(px_ff);
               red_d = L'(mul_p);
               red_neg = aneg_ff ^ bneg_ff;
            end else if (kind_ff == rau_pkg::KIND_DIV) begin
               red_go = 1'b1;
               red_n = L'(px_ff);
               red_d = L'(py_ff);
               red_neg = aneg_ff ^ bneg_ff;
            end else if (kind_ff == rau_pkg::KIND_CMP) begin
               state_in = rau_pkg::ST_CMP;
            end else begin
               state_in = rau_pkg::ST_ADD;
            end
         end

         // Signed sum of the cross products.
         rau_pkg::ST_ADD: begin
            sy = ((kind_ff == rau_pkg::KIND_SUB) ? !bneg_ff : bneg_ff) && (bn_ff != '0);
            alu_x = AW'(px_ff);
            alu_y = AW'(py_ff);
            alu_sub = (aneg_ff != sy);
            if (!alu_sub) begin
               red_go = 1'b1;
               red_n = alu_sum[L-1:0];
               red_d = L'(pz_ff);
               red_neg = aneg_ff;
            end else if (!alu_borrow) begin
               red_go = 1'b1;
               red_n = alu_sum[L-1:0];
               red_d = L'(pz_ff);
               red_neg = aneg_ff;
            end else begin
               state_in = rau_pkg::ST_SUB2;
            end
         end
         rau_pkg::ST_SUB2: begin
            sy = ((kind_ff == rau_pkg::KIND_SUB) ? !bneg_ff : bneg_ff) && (bn_ff != '0);
            alu_x = AW'(py_ff);
            alu_y = AW'(px_ff);
            red_go = 1'b1;
            red_n = alu_sum[L-1:0];
            red_d = L'(pz_ff);
            red_neg = sy;
         end

         // Compare the cross products.
         rau_pkg::ST_CMP: begin
            alu_x = AW'(px_ff);
            alu_y = AW'(py_ff);
            if (aneg_ff != bneg_ff) begin
               o_less_in = aneg_ff;
            end else if (aneg_ff) begin
               o_less_in = !alu_borrow && (alu_sum[AW-1:0] != '0);
            end else begin
               o_less_in = alu_borrow;
            end
            o_eq_in = (aneg_ff == bneg_ff) && (alu_sum[AW-1:0] == '0);
            state_in = rau_pkg::ST_OUT;
         end

         // Range check of a reduced fraction.
         rau_pkg::ST_EMIT: begin
            bad = (rd_ff > (LIM - L'(1))) ||
                  (rneg_ff ? (rn_ff > LIM) : (rn_ff > (LIM - L'(1))));
            n32 = 32'(rn_ff);
            if (bad) begin
               o_err_in = rau_pkg::ERR_OVF;
            end else begin
               o_num_in = rneg_ff ? (32'd0 - n32) : n32;
               o_den_in = 31'(rd_ff);
            end
            state_in = rau_pkg::ST_OUT;
         end

         // Hand the item to the output register once it is free.
         rau_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in = o_num_ff;
               rsp_den_in = o_den_ff;
               rsp_int_in = o_int_ff;
               rsp_less_in = o_less_ff;
               rsp_eq_in = o_eq_ff;
               rsp_err_in = o_err_ff;
               state_in = rau_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rau_pkg::ST_IDLE;
         end
      endcase

      // Launch a reduction of red_n / red_d.
      if (red_go) begin
         u_in = red_n;
         v_in = red_d;
         rn_in = red_n;
         rd_in = red_d;
         rneg_in = red_neg;
         k_in = '0;
         phase_in = red_phase;
         state_in = rau_pkg::ST_GCD;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers.
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      kind_ff <= kind_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      aneg_ff <= aneg_in;
      bneg_ff <= bneg_in;
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      dcnt_ff <= dcnt_in;
      rn_ff <= rn_in;
      rd_ff <= rd_in;
      rneg_ff <= rneg_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      o_num_ff <= o_num_in;
      o_den_ff <= o_den_in;
      o_int_ff <= o_int_in;
      o_less_ff <= o_less_in;
      o_eq_ff <= o_eq_in;
      o_err_ff <= o_err_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_int_ff <= rsp_int_in;
      rsp_less_ff <= rsp_less_in;
      rsp_eq_ff <= rsp_eq_in;
      rsp_err_ff <= rsp_err_in;
   end

   // Checks on the sequencer and the result item.
   `RAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "block still ready after taking an item")
   `RAU_ASSERT_SAME(a_error_clears_fields, clock, reset, rsp_valid_ff && (rsp_err_ff != rau_pkg::ERR_NONE), (rsp_num_ff == '0) && (rsp_den_ff == '0) && (rsp_int_ff == '0), "error item carries data")
   `RAU_ASSERT_SAME(a_less_excludes_equal, clock, reset, rsp_valid_ff, !(rsp_less_ff && rsp_eq_ff), "compare reports less and equal together")

endmodule
